FILE: rtl/swrc_pkg.sv
// ----------------------------------------------------------------------------
// swrc_pkg
// Types and codes shared by the sliding-window rate counter block.
// ----------------------------------------------------------------------------
package swrc_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    OP_COLLECT = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     operation;
    logic [IdxW-1:0]         counter_index;
    logic signed [DataW-1:0] amount;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] rate;
    logic signed [DataW-1:0] total;
  } out_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    op_e              op;
    logic             hit;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] amount;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COLLECT,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_DONE,
    ST_WALK
  } st_e;

endpackage

FILE: rtl/swrc_front.sv
// ----------------------------------------------------------------------------
// swrc_front
// Input stage: takes transfers and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module swrc_front #(
  parameter int unsigned COUNTERS = 1024
) (
  input  logic          in_valid_i,
  input  swrc_pkg::in_t in_data_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output swrc_pkg::cmd_t push_cmd_o
);
  import swrc_pkg::*;

  localparam int unsigned CmpW = 17;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_cmd_o.op     = in_data_i.operation;
    push_cmd_o.hit    = {{(CmpW-IdxW){1'b0}}, in_data_i.counter_index} < CmpW'(COUNTERS);
    push_cmd_o.idx    = in_data_i.counter_index;
    push_cmd_o.amount = in_data_i.amount;
  end

endmodule

FILE: rtl/swrc_queue.sv
// ----------------------------------------------------------------------------
// swrc_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module swrc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swrc_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output swrc_pkg::cmd_t data_o,
  input  logic           pop_i
);
  import swrc_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/swrc_back.sv
// ----------------------------------------------------------------------------
// swrc_back
// Execution engine: bucket banks, totals, window sum and divide by window.
// ----------------------------------------------------------------------------
module swrc_back #(
  parameter int unsigned COUNTERS = 1024,
  parameter int unsigned WINDOW   = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  swrc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swrc_pkg::out_t out_data_o
);
  import swrc_pkg::*;

  localparam int unsigned AW = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int unsigned JW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // divide in 16-bit digits; the remainder stays below WINDOW, at most 64
  localparam int unsigned DigW  = 16;
  localparam int unsigned DigN  = DataW / DigW;
  localparam int unsigned RemW  = 6;
  localparam int unsigned NumW  = RemW + DigW;
  localparam int unsigned RecS  = NumW + RemW;
  localparam int unsigned RecW  = RecS + 1;
  localparam int unsigned ProdW = NumW + RecW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << RecS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  st_e              state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [JW-1:0]    head_q, head_d;
  logic [JW-1:0]    j_q, j_d;
  logic [1:0]       dig_q, dig_d;
  logic             out_valid_q, out_valid_d;

  cmd_t             cmd_q, cmd_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             neg_q, neg_d;
  out_t             out_q, out_d;

  logic [DataW-1:0] row_q [WINDOW];
  logic [DataW-1:0] total_rd_q;
  logic [DataW-1:0] total_mem [COUNTERS];

  logic [WINDOW-1:0] bank_we;
  logic              total_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              rd_en;
  logic [DataW-1:0]  bank_wdata;
  logic [DataW-1:0]  total_wdata;
  logic [NumW-1:0]   div_num;
  logic [ProdW-1:0]  div_prod;
  logic [DigW-1:0]   div_qdig;
  logic [NumW-1:0]   div_back;
  logic [AW-1:0]     cmd_addr;
  logic [AW-1:0]     cur_addr;

  assign cmd_addr = AW'({{AW{1'b0}}, cmd_i.idx});
  assign cur_addr = AW'({{AW{1'b0}}, cmd_q.idx});
  assign raddr    = cmd_addr;

  // one quotient digit a cycle by reciprocal multiplication
  assign div_num  = {rem_q, quo_q[DataW-1 -: DigW]};
  assign div_prod = ProdW'(div_num) * ProdW'(Recip);
  assign div_qdig = div_prod[RecS +: DigW];
  assign div_back = NumW'(div_qdig) * NumW'(WINDOW);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    j_d         = j_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    bank_we     = '0;
    total_we    = 1'b0;
    waddr       = cnt_q;
    bank_wdata  = '0;
    total_wdata = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        bank_we  = '1;
        total_we = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q == AW'(COUNTERS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.op)
            OP_COLLECT: begin
              if (cmd_i.hit) begin
                rd_en   = 1'b1;
                state_d = ST_COLLECT;
              end
            end
            OP_TICK: begin
              head_d  = (head_q == '0) ? JW'(WINDOW - 1) : head_q - JW'(1);
              cnt_d   = '0;
              state_d = ST_WALK;
            end
            OP_READ: begin
              if (cmd_i.hit) begin
                rd_en   = 1'b1;
                j_d     = '0;
                acc_d   = '0;
                state_d = ST_SUM;
              end else begin
                quo_d   = '0;
                neg_d   = 1'b0;
                state_d = ST_DONE;
              end
            end
            OP_CLEAR: begin
              if (cmd_i.hit) begin
                waddr    = cmd_addr;
                bank_we  = '1;
                total_we = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_COLLECT: begin
        waddr           = cur_addr;
        bank_we[head_q] = 1'b1;
        total_we        = 1'b1;
        bank_wdata      = row_q[head_q] + cmd_q.amount;
        total_wdata     = total_rd_q + cmd_q.amount;
        state_d         = ST_IDLE;
      end
      ST_SUM: begin
        acc_d = acc_q + row_q[j_q];
        j_d   = j_q + JW'(1);
        if (j_q == JW'(WINDOW - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        neg_d   = acc_q[DataW-1];
        quo_d   = acc_q[DataW-1] ? (~acc_q) + DataW'(1) : acc_q;
        rem_d   = '0;
        dig_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // long division by the window length, most significant digit first
        rem_d = RemW'(div_num - div_back);
        quo_d = {quo_q[DataW-DigW-1:0], div_qdig};
        dig_d = dig_q + 2'd1;
        if (dig_q == 2'(DigN - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.rate  = neg_q ? (~quo_q) + DataW'(1) : quo_q;
          out_d.total = cmd_q.hit ? total_rd_q : '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_WALK: begin
        bank_we[head_q] = 1'b1;
        cnt_d           = cnt_q + AW'(1);
        if (cnt_q == AW'(COUNTERS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      head_q      <= '0;
      j_q         <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      j_q         <= j_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  for (genvar b = 0; b < WINDOW; b++) begin : g_bank
    logic [DataW-1:0] bank_mem [COUNTERS];

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        bank_mem[waddr] <= bank_wdata;
      end
      if (rd_en) begin
        row_q[b] <= bank_mem[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (total_we) begin
      total_mem[waddr] <= total_wdata;
    end
    if (rd_en) begin
      total_rd_q <= total_mem[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/sliding_window_rate_counters.sv
// Commands run one at a time in the back end; the two-entry queue takes transfers meanwhile.
// Throughput is set by the back end: the bank read-modify-write, the four-digit divide
// and the tick walk over all counters, one counter per cycle.
// After reset a clearing pass over all COUNTERS entries zeroes the store; queued transfers then run.
// ----------------------------------------------------------------------------
// sliding_window_rate_counters
// Table of counters with windowed buckets, running totals and rate readout.
// ----------------------------------------------------------------------------
module sliding_window_rate_counters #(
  parameter int unsigned COUNTERS = 1024,
  parameter int unsigned WINDOW   = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swrc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swrc_pkg::out_t out_data_o
);
  import swrc_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  swrc_front #(
    .COUNTERS(COUNTERS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_ready_o(in_ready_o),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_cmd_o(push_cmd)
  );

  swrc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .data_o     (q_cmd),
    .pop_i      (q_pop)
  );

  swrc_back #(
    .COUNTERS(COUNTERS),
    .WINDOW  (WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: tb/swrc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swrc_checker
// Watches both channels of the rate counter block. Keeps its own bucket and
// total tables, predicts every read result and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module swrc_checker #(
  parameter int unsigned COUNTERS = 1024,
  parameter int unsigned WINDOW   = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  swrc_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  swrc_pkg::out_t out_data_i,
  output int             mismatches_o,
  output int             pending_o
);
  import swrc_pkg::*;

  logic [DataW-1:0] bucket_mem [COUNTERS][WINDOW];
  logic [DataW-1:0] total_mem  [COUNTERS];
  out_t             expected_readings [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    foreach (bucket_mem[c, j]) bucket_mem[c][j] = '0;
    foreach (total_mem[c]) total_mem[c] = '0;
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    if (mismatches_o < 50) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  task automatic apply_command(input in_t cmd);
    longint win_sum;
    out_t   reading;
    logic   hit;
    hit = cmd.counter_index < COUNTERS;
    case (cmd.operation)
      OP_COLLECT: begin
        if (hit) begin
          bucket_mem[cmd.counter_index][0] += cmd.amount;
          total_mem[cmd.counter_index]     += cmd.amount;
        end
      end
      OP_TICK: begin
        foreach (total_mem[c]) begin
          for (int j = WINDOW - 1; j > 0; j--) bucket_mem[c][j] = bucket_mem[c][j-1];
          bucket_mem[c][0] = '0;
        end
      end
      OP_READ: begin
        reading = '0;
        if (hit) begin
          win_sum = 0;
          for (int j = 0; j < WINDOW; j++) win_sum += longint'(bucket_mem[cmd.counter_index][j]);
          // signed division truncates toward zero
          reading.rate  = win_sum / longint'(WINDOW);
          reading.total = total_mem[cmd.counter_index];
        end
        expected_readings.push_back(reading);
      end
      default: begin
        if (hit) begin
          for (int j = 0; j < WINDOW; j++) bucket_mem[cmd.counter_index][j] = '0;
          total_mem[cmd.counter_index] = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      // results first: a read taken on this edge cannot answer on the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result transfer with none expected", out_data_i.rate, '0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data_i.rate !== want.rate) begin
            report_mismatch("rate", out_data_i.rate, want.rate);
          end
          if (out_data_i.total !== want.total) begin
            report_mismatch("total", out_data_i.total, want.total);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
      pending_o <= expected_readings.size();
    end
  end

endmodule

FILE: tb/tb_sliding_window_rate_counters.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_counters
// Drives collect, tick, read and clear commands into the rate counter block:
// a directed opening over extremes, wrap, negative rates, clears and window
// ageing, then random traffic concentrated on a few counters, with random
// idle bursts on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_counters;
  import swrc_pkg::*;

  localparam int unsigned COUNTERS     = 1024;
  localparam int unsigned WINDOW       = 5;
  localparam int unsigned ITEMS        = 2000;
  localparam int unsigned DIRECTED     = 22;
  localparam int unsigned CALM_FROM    = 1700;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 2 * (COUNTERS + WINDOW + 70);

  localparam logic signed [DataW-1:0] AMT_MAX = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] AMT_MIN = {1'b1, {(DataW-1){1'b0}}};

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic calm  = 1'b0;
  logic quiet = 1'b0;
  int   stall_left  = 0;
  int   idle_cycles = 0;
  int   mismatches;
  int   pending;

  logic [IdxW-1:0] hot_idx [8];

  always #2 clk_i = ~clk_i;

  sliding_window_rate_counters #(
    .COUNTERS (COUNTERS),
    .WINDOW   (WINDOW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  swrc_checker #(
    .COUNTERS (COUNTERS),
    .WINDOW   (WINDOW)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // result side back-pressure in bursts, with quiet stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) quiet <= ~quiet;
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DataW-1:0] draw_amount();
    case ($urandom_range(0, 9))
      0:       return AMT_MAX;
      1:       return AMT_MIN;
      2:       return '1;
      3, 4, 5: return {$urandom, $urandom};
      default: return DataW'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic in_t draw_command();
    in_t cmd;
    int  pick;
    pick = $urandom_range(0, 99);
    cmd.counter_index = ($urandom_range(0, 99) < 85) ? hot_idx[$urandom_range(0, 7)]
                                                       : IdxW'($urandom);
    cmd.amount = {$urandom, $urandom};
    if (pick < 55) begin
      cmd.operation = OP_COLLECT;
      cmd.amount    = draw_amount();
    end else if (pick < 80) begin
      cmd.operation = OP_READ;
    end else if (pick < 84) begin
      cmd.operation = OP_CLEAR;
    end else if (pick < 86) begin
      cmd.operation = OP_TICK;
    end else begin
      cmd.operation     = op_e'($urandom_range(0, 3));
      cmd.counter_index = IdxW'($urandom);
      cmd.amount        = draw_amount();
    end
    return cmd;
  endfunction

  task automatic send(input in_t cmd);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic issue(input op_e op, input logic [IdxW-1:0] idx,
                       input logic [DataW-1:0] amt);
    in_t cmd;
    cmd.operation     = op;
    cmd.counter_index = idx;
    cmd.amount        = amt;
    send(cmd);
  endtask

  initial begin
    foreach (hot_idx[k]) hot_idx[k] = IdxW'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wrap of bucket and total
    issue(OP_COLLECT, 10'd0, AMT_MAX);
    issue(OP_COLLECT, 10'd0, AMT_MAX);
    issue(OP_READ, 10'd0, {$urandom, $urandom});
    // most negative amount, negative rates truncated toward zero
    issue(OP_COLLECT, 10'd1023, AMT_MIN);
    issue(OP_READ, 10'd1023, '1);
    issue(OP_COLLECT, 10'h155, -64'sd7);
    issue(OP_READ, 10'h155, '0);
    // alternating bit patterns
    issue(OP_COLLECT, 10'h2AA, 64'h5555_5555_5555_5555);
    issue(OP_COLLECT, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_TICK, 10'd1023, '1);
    issue(OP_COLLECT, 10'h2AA, 64'sd13);
    issue(OP_READ, 10'h2AA, 64'h5555_5555_5555_5555);
    issue(OP_CLEAR, 10'h2AA, '0);
    issue(OP_READ, 10'h2AA, '0);
    issue(OP_CLEAR, 10'd0, '1);
    issue(OP_READ, 10'd0, '0);
    // age the early buckets out of the window, totals stay
    repeat (4) issue(OP_TICK, IdxW'($urandom), {$urandom, $urandom});
    issue(OP_READ, 10'd1023, '0);
    issue(OP_READ, 10'h155, '0);

    for (int n = DIRECTED; n < ITEMS; n++) begin
      if (n == CALM_FROM) calm <= 1'b1;
      send(draw_command());
    end
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sliding_window_rate_counters.f
rtl/swrc_pkg.sv
rtl/swrc_front.sv
rtl/swrc_queue.sv
rtl/swrc_back.sv
rtl/sliding_window_rate_counters.sv
tb/swrc_checker.sv
tb/tb_sliding_window_rate_counters.sv
